/* sv/ssd_pkg.sv */
// ----------------------------------------------------------------------------
// ssd_pkg: shared types, constants and code tables for the scan driver
// Holds the action codes, the stage record passed from the input register to
// the display core, the reciprocal constants for the decimal split and the
// segment code tables for numerals and letters.
// ----------------------------------------------------------------------------
package ssd_pkg;

    localparam int DIGIT_COUNT = 4;
    localparam int SCAN_W      = $clog2(DIGIT_COUNT);
    localparam int VALUE_W     = 16;
    localparam int LETTER_W    = 7;
    localparam int SEG_W       = 8;
    localparam int IN_DATA_W   = 48;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 16;
    localparam int DUR_W       = 16;

    localparam logic [DUR_W-1:0] DURATION_RESET = 16'd1000;

    // Action codes carried in tuser
    typedef logic [1:0] t_action;
    localparam t_action ACT_TICK    = 2'd0;
    localparam t_action ACT_NUMBER  = 2'd1;
    localparam t_action ACT_MESSAGE = 2'd2;

    // Decimal point placement
    localparam logic [SEG_W-1:0]  POINT_BIT   = 8'b0000_0001;
    localparam logic [SCAN_W-1:0] POINT_DIGIT = 2'd2;
    localparam logic [SEG_W-1:0]  SELECT_MSB  = 8'b1000_0000;

    // Reciprocal multipliers: floor(v / D) == (v * M) >> S for every 16-bit v
    localparam logic [16:0] MUL_1000   = 17'd67109;
    localparam int          SHIFT_1000 = 26;
    localparam logic [17:0] MUL_100    = 18'd167773;
    localparam int          SHIFT_100  = 24;
    localparam logic [15:0] MUL_10     = 16'd52429;
    localparam int          SHIFT_10   = 19;

    // Letter clamp range
    localparam logic [LETTER_W-1:0] LETTER_FIRST = 7'h61;
    localparam logic [LETTER_W-1:0] LETTER_LAST  = 7'h7A;
    localparam logic [4:0]          LETTER_TOP   = 5'd25;
    localparam logic [3:0]          DIGIT_TOP    = 4'd9;

    // Record handed from the input register to the display core
    typedef struct packed {
        t_action                            action;
        logic [VALUE_W-1:0]                 value;
        logic [6:0]                         q1000;
        logic [9:0]                         q100;
        logic [12:0]                        q10;
        logic [DIGIT_COUNT-1:0][LETTER_W-1:0] letter;
    } t_stage;

    // Segment code of a decimal digit
    function automatic logic [SEG_W-1:0] numeral_code(input logic [3:0] d);
        logic [SEG_W-1:0] code;
        case (d)
            4'd0:    code = 8'b1111_1100;
            4'd1:    code = 8'b0110_0000;
            4'd2:    code = 8'hDA;
            4'd3:    code = 8'hF2;
            4'd4:    code = 8'h66;
            4'd5:    code = 8'hB6;
            4'd6:    code = 8'hBE;
            4'd7:    code = 8'hE0;
            4'd8:    code = 8'hFE;
            4'd9:    code = 8'hF6;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

    // Segment code of an ASCII letter, clamped to a..z
    function automatic logic [SEG_W-1:0] letter_code(input logic [LETTER_W-1:0] c);
        logic [4:0]       idx;
        logic [LETTER_W-1:0] off;
        logic [SEG_W-1:0] code;
        off = c - LETTER_FIRST;
        if (c < LETTER_FIRST) begin
            idx = 5'd0;
        end else if (c > LETTER_LAST) begin
            idx = LETTER_TOP;
        end else begin
            idx = off[4:0];
        end
        case (idx)
            5'd0:    code = 8'b1110_1110;
            5'd1:    code = 8'h3E;
            5'd2:    code = 8'h9C;
            5'd3:    code = 8'h7A;
            5'd4:    code = 8'h9E;
            5'd5:    code = 8'h8E;
            5'd6:    code = 8'hBE;
            5'd7:    code = 8'h6E;
            5'd8:    code = 8'h60;
            5'd9:    code = 8'h70;
            5'd11:   code = 8'h1C;
            5'd12:   code = 8'hEC;
            5'd13:   code = 8'h2A;
            5'd14:   code = 8'hFC;
            5'd15:   code = 8'hCE;
            5'd16:   code = 8'hE6;
            5'd17:   code = 8'h8C;
            5'd18:   code = 8'hB6;
            5'd19:   code = 8'h1E;
            5'd20:   code = 8'h7C;
            5'd24:   code = 8'h70;
            5'd25:   code = 8'h66;
            default: code = 8'h00;  // k, v, w, x have no shape
        endcase
        return code;
    endfunction

endpackage

/* sv/seven_segment_scan_driver.sv */
// ----------------------------------------------------------------------------
// seven_segment_scan_driver: four-digit multiplexed seven-segment driver
// Takes set-number, set-message and refresh-tick transactions and returns
// one select/segment pair per refresh tick.
//
//   Channel   Direction  Content
//   s_axis    in         tuser: action; tdata: value, letter_0..letter_3
//   m_axis    out        tdata: digit_select, segment_bits
//   cfg       in         message_duration write, no read-back
//
// One transaction per cycle is accepted while the result stream is not stalled;
// a tick's result passes through the input register, then the result register,
// and completes once the receiver takes it.
// The reciprocal multipliers sit before the input register, the digit
// remainders and code tables before the state and result registers.
// Reset is synchronous, active low; duration returns to 1000.
// A stalled result holds the next tick in the input register, which then
// blocks all input; set items ahead of that tick still pass.
// ----------------------------------------------------------------------------
module seven_segment_scan_driver
    import ssd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // value[15:0], letter_0[22:16],
                                                 // letter_1[29:23], letter_2[36:30],
                                                 // letter_3[43:37], zeros[47:44]
    input  logic [IN_USER_W-1:0]  s_axis_tuser,  // action[1:0]
    // master stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // digit_select[7:0], segment_bits[15:8]
    // configuration
    input  logic                  i_cfg_wr_en,
    input  logic [DUR_W-1:0]      i_cfg_wr_data
);

    logic   w_load;
    logic   w_take;
    logic   w_stage_valid;
    t_stage w_stage;

    // Accept when the input register is empty or being drained
    assign s_axis_tready = !w_stage_valid || w_take;
    assign w_load        = s_axis_tvalid && s_axis_tready;

    ssd_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_load),
        .i_advance (w_take),
        .i_tdata   (s_axis_tdata),
        .i_tuser   (s_axis_tuser),
        .o_valid   (w_stage_valid),
        .o_stage   (w_stage)
    );

    ssd_disp u_disp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_stage_valid),
        .i_stage       (w_stage),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_m_tready    (m_axis_tready),
        .o_take        (w_take),
        .o_m_tvalid    (m_axis_tvalid),
        .o_m_tdata     (m_axis_tdata)
    );

endmodule

/* sv/ssd_in_stage.sv */
// ----------------------------------------------------------------------------
// ssd_in_stage: input register of the scan driver
// Captures each accepted transaction together with the reciprocal products
// of the value (value/1000, value/100, value/10) for the decimal split.
// ----------------------------------------------------------------------------
module ssd_in_stage
    import ssd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  logic                 i_advance,
    input  logic [IN_DATA_W-1:0] i_tdata,
    input  logic [IN_USER_W-1:0] i_tuser,
    output logic                 o_valid,
    output t_stage               o_stage
);

    logic               r_valid;
    t_stage             r_stage;
    t_stage             n_stage;
    logic [VALUE_W-1:0] w_value;
    logic [32:0]        w_p1000;
    logic [33:0]        w_p100;
    logic [31:0]        w_p10;

    // Reciprocal products of the incoming value
    assign w_value = i_tdata[VALUE_W-1:0];
    assign w_p1000 = 33'(w_value) * 33'(MUL_1000);
    assign w_p100  = 34'(w_value) * 34'(MUL_100);
    assign w_p10   = 32'(w_value) * 32'(MUL_10);

    // Unpack the transaction into the stage record
    always_comb begin
        n_stage.action    = i_tuser;
        n_stage.value     = w_value;
        n_stage.q1000     = w_p1000[SHIFT_1000 +: 7];
        n_stage.q100      = w_p100[SHIFT_100 +: 10];
        n_stage.q10       = w_p10[SHIFT_10 +: 13];
        n_stage.letter[0] = i_tdata[22:16];
        n_stage.letter[1] = i_tdata[29:23];
        n_stage.letter[2] = i_tdata[36:30];
        n_stage.letter[3] = i_tdata[43:37];
    end

    // Hold the valid flag until the core takes the item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    // Capture payload on accept
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

/* sv/ssd_disp.sv */
// ----------------------------------------------------------------------------
// ssd_disp: display state and result register of the scan driver
// Finishes the decimal split, stores number and message segment codes,
// tracks message age and scan position, and registers one result per tick.
// ----------------------------------------------------------------------------
module ssd_disp
    import ssd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  t_stage                i_stage,
    input  logic                  i_cfg_wr_en,
    input  logic [DUR_W-1:0]      i_cfg_wr_data,
    input  logic                  i_m_tready,
    output logic                  o_take,
    output logic                  o_m_tvalid,
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    logic [DUR_W-1:0]      r_duration;
    logic [SCAN_W-1:0]     r_scan;
    logic [DUR_W-1:0]      r_age;
    logic                  r_shown;
    logic [SEG_W-1:0]      r_num_seg [DIGIT_COUNT];
    logic [SEG_W-1:0]      r_msg_seg [DIGIT_COUNT];
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic                  w_is_tick;
    logic                  w_slot_free;
    logic [3:0]            w_digit [DIGIT_COUNT];
    logic [9:0]            w_ten_q1000;
    logic [12:0]           w_ten_q100;
    logic [15:0]           w_ten_q10;
    logic [9:0]            w_rem1;
    logic [12:0]           w_rem2;
    logic [15:0]           w_rem3;
    logic [SEG_W-1:0]      w_seg;
    logic [SEG_W-1:0]      w_sel;

    // Take the item when it produces no result or the result slot is free
    assign w_is_tick   = (i_stage.action == ACT_TICK);
    assign w_slot_free = !r_out_valid || i_m_tready;
    assign o_take      = i_valid && (!w_is_tick || w_slot_free);

    // Decimal digits from the reciprocal quotients
    assign w_ten_q1000 = 10'({i_stage.q1000, 3'b000}) + 10'({i_stage.q1000, 1'b0});
    assign w_ten_q100  = 13'({i_stage.q100, 3'b000}) + 13'({i_stage.q100, 1'b0});
    assign w_ten_q10   = 16'({i_stage.q10, 3'b000}) + 16'({i_stage.q10, 1'b0});
    assign w_rem1      = i_stage.q100 - w_ten_q1000;
    assign w_rem2      = i_stage.q10 - w_ten_q100;
    assign w_rem3      = i_stage.value - w_ten_q10;

    always_comb begin
        w_digit[0] = (i_stage.q1000 > 7'(DIGIT_TOP)) ? DIGIT_TOP : i_stage.q1000[3:0];
        w_digit[1] = w_rem1[3:0];
        w_digit[2] = w_rem2[3:0];
        w_digit[3] = w_rem3[3:0];
    end

    // Pick the segment byte of the current digit
    always_comb begin
        if (r_shown) begin
            w_seg = r_msg_seg[r_scan];
        end else if (r_scan == POINT_DIGIT) begin
            w_seg = r_num_seg[r_scan] | POINT_BIT;
        end else begin
            w_seg = r_num_seg[r_scan];
        end
        w_sel = SELECT_MSB >> r_scan;
    end

    // Duration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duration <= DURATION_RESET;
        end else if (i_cfg_wr_en) begin
            r_duration <= i_cfg_wr_data;
        end
    end

    // Scan position, message flag and age
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan  <= '0;
            r_age   <= '0;
            r_shown <= 1'b0;
        end else if (o_take) begin
            case (i_stage.action)
                ACT_MESSAGE: begin
                    r_shown <= 1'b1;
                    r_age   <= '0;
                end
                ACT_TICK: begin
                    r_scan <= r_scan + 1'b1;
                    if (r_age < r_duration) begin
                        r_age <= r_age + 1'b1;
                    end else begin
                        r_shown <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Number segment codes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                r_num_seg[i] <= '0;
            end
        end else if (o_take && (i_stage.action == ACT_NUMBER)) begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                r_num_seg[i] <= numeral_code(w_digit[i]);
            end
        end
    end

    // Message segment codes
    always_ff @(posedge i_clk) begin
        if (o_take && (i_stage.action == ACT_MESSAGE)) begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                r_msg_seg[i] <= letter_code(i_stage.letter[i]);
            end
        end
    end

    // Result register: load on tick, drop once the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take && w_is_tick) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && w_is_tick) begin
            r_out_data <= {w_seg, w_sel};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // A stalled result is never overwritten by a new tick
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |-> !(o_take && w_is_tick))
        else $error("tick taken while result register is stalled");

    // Each tick advances the scan by exactly one digit
    a_scan_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && w_is_tick) |=> (r_scan == $past(r_scan) + 2'd1))
        else $error("scan position did not advance on tick");

    // A message item arms the flag and clears the age
    a_msg_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && (i_stage.action == ACT_MESSAGE)) |=> (r_shown && (r_age == '0)))
        else $error("message not armed");

    // The select byte in the result register is one-hot
    a_sel_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $onehot(r_out_data[SEG_W-1:0]))
        else $error("digit select not one-hot");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the seven-segment scan driver
// A directed pass covers reset codes, number saturation, the letter clamps,
// shapeless letters and the unused action. Random phases then mix refresh
// ticks, number loads and message loads under several message durations.
// Sender gaps and receiver stalls vary between phases. A scoreboard predicts
// each tick readout and compares it with the result stream in order.
// ----------------------------------------------------------------------------
module tb_top;
    import ssd_pkg::*;

    localparam t_action    ACT_UNUSED   = 2'd3;
    localparam int         LIMIT_CYCLES = 200000;
    localparam int         PIPE_SETTLE  = 4;
    localparam int         END_SETTLE   = 8;
    localparam logic [6:0] ASCII_A      = 7'h61;
    localparam logic [6:0] ASCII_Z      = 7'h7A;

    typedef struct packed {
        logic [7:0] select;
        logic [7:0] segments;
    } t_readout;

    // Display state mirror and queue of predicted tick readouts
    class display_tracker;
        logic [15:0] duration;
        logic [1:0]  scan_pos;
        logic [15:0] age;
        bit          shown;
        logic [7:0]  number_code [4];
        logic [7:0]  message_code [4];
        logic [7:0]  numeral_shape [10];
        logic [7:0]  letter_shape [26];
        t_readout    pending_readouts [$];
        int unsigned mismatches;
        int unsigned checked;

        function new();
            numeral_shape = '{8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66,
                              8'hB6, 8'hBE, 8'hE0, 8'hFE, 8'hF6};
            // k, v, w and x have no shape and stay blank
            letter_shape = '{8'hEE, 8'h3E, 8'h9C, 8'h7A, 8'h9E, 8'h8E, 8'hBE,
                             8'h6E, 8'h60, 8'h70, 8'h00, 8'h1C, 8'hEC, 8'h2A,
                             8'hFC, 8'hCE, 8'hE6, 8'h8C, 8'hB6, 8'h1E, 8'h7C,
                             8'h00, 8'h00, 8'h00, 8'h70, 8'h66};
            duration   = DURATION_RESET;
            scan_pos   = '0;
            age        = '0;
            shown      = 1'b0;
            mismatches = 0;
            checked    = 0;
            number_code  = '{default: 8'h00};
            message_code = '{default: 8'h00};
        endfunction

        function void set_duration(logic [15:0] v);
            duration = v;
        endfunction

        // Update the mirror for one accepted input transaction
        function void note_transaction(t_action act, logic [15:0] value,
                                       logic [3:0][6:0] letters);
            int       thousands;
            int       idx;
            t_readout readout;
            case (act)
                ACT_NUMBER: begin
                    // saturate the leading digit at nine
                    thousands = value / 1000;
                    if (thousands > 9) begin
                        thousands = 9;
                    end
                    number_code[0] = numeral_shape[thousands];
                    number_code[1] = numeral_shape[(value % 1000) / 100];
                    number_code[2] = numeral_shape[(value % 100) / 10];
                    number_code[3] = numeral_shape[value % 10];
                end
                ACT_MESSAGE: begin
                    // clamp each letter into a..z
                    for (int i = 0; i < DIGIT_COUNT; i++) begin
                        if (letters[i] < ASCII_A) begin
                            idx = 0;
                        end else if (letters[i] > ASCII_Z) begin
                            idx = 25;
                        end else begin
                            idx = letters[i] - ASCII_A;
                        end
                        message_code[i] = letter_shape[idx];
                    end
                    shown = 1'b1;
                    age   = '0;
                end
                ACT_TICK: begin
                    readout.select = SELECT_MSB >> scan_pos;
                    if (shown) begin
                        readout.segments = message_code[scan_pos];
                    end else begin
                        readout.segments = number_code[scan_pos];
                        if (scan_pos == POINT_DIGIT) begin
                            readout.segments = readout.segments | POINT_BIT;
                        end
                    end
                    pending_readouts.push_back(readout);
                    // advance the scan, then age or drop the message
                    scan_pos = scan_pos + 2'd1;
                    if (age < duration) begin
                        age = age + 16'd1;
                    end else begin
                        shown = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        endfunction

        // Compare one output transaction with the oldest prediction
        function void check_readout(logic [15:0] word);
            t_readout want;
            if (pending_readouts.size() == 0) begin
                $display("%0t: unexpected readout select=%h segments=%h",
                         $time, word[7:0], word[15:8]);
                mismatches++;
                return;
            end
            want = pending_readouts.pop_front();
            checked++;
            if (word[7:0] !== want.select) begin
                $display("%0t: digit_select expected %h actual %h",
                         $time, want.select, word[7:0]);
                mismatches++;
            end
            if (word[15:8] !== want.segments) begin
                $display("%0t: segment_bits expected %h actual %h",
                         $time, want.segments, word[15:8]);
                mismatches++;
            end
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // value, letter_0..letter_3, zeros
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;  // action
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // digit_select, segment_bits
    logic                  i_cfg_wr_en   = 1'b0;
    logic [DUR_W-1:0]      i_cfg_wr_data = '0;

    display_tracker tracker;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count   = 0;
    int n_ticks       = 0;
    int n_numbers     = 0;
    int n_messages    = 0;
    int n_ignored     = 0;

    seven_segment_scan_driver dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Stall the result stream at random
    always @(negedge i_clk) begin
        m_axis_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
    end

    // Check every accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            tracker.check_readout(m_axis_tdata);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("%0t: timeout, %0d readouts still pending",
                     $time, tracker.pending_readouts.size());
            $display("status: fail");
            $finish;
        end
    end

    // Offer one transaction, with random gaps ahead of it; entered at a falling edge
    task automatic send_item(input t_action act, input logic [15:0] value,
                             input logic [3:0][6:0] letters);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {4'b0000, letters, value};
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.note_transaction(act, value, letters);
        case (act)
            ACT_TICK:    n_ticks++;
            ACT_NUMBER:  n_numbers++;
            ACT_MESSAGE: n_messages++;
            default:     n_ignored++;
        endcase
        @(negedge i_clk);
    endtask

    // Wait for all readouts and let the pipeline settle
    task automatic drain_display();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending_readouts.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (PIPE_SETTLE) @(negedge i_clk);
    endtask

    task automatic write_duration(input logic [15:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        tracker.set_duration(v);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // One random phase under a given duration and idling mix
    task automatic run_phase(input int count, input logic [15:0] dur,
                             input int send_pct, input int recv_pct);
        int              done;
        int              pick;
        t_action         act;
        logic [15:0]     value;
        logic [3:0][6:0] letters;
        drain_display();
        write_duration(dur);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(99);
            if (pick < 62) begin
                act = ACT_TICK;
            end else if (pick < 80) begin
                act = ACT_NUMBER;
            end else if (pick < 94) begin
                act = ACT_MESSAGE;
            end else begin
                act = ACT_UNUSED;
            end
            // bias numbers toward digit and saturation boundaries
            if ($urandom_range(3) == 0) begin
                case ($urandom_range(5))
                    0:       value = 16'd0;
                    1:       value = 16'd999;
                    2:       value = 16'd1000;
                    3:       value = 16'd9999;
                    4:       value = 16'd10000;
                    default: value = 16'hFFFF;
                endcase
            end else begin
                value = 16'($urandom_range(16'hFFFF));
            end
            // mostly real letters, some anywhere in the 7-bit range
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                if ($urandom_range(4) == 0) begin
                    letters[i] = 7'($urandom_range(7'h7F));
                end else begin
                    letters[i] = 7'($urandom_range(ASCII_Z, ASCII_A));
                end
            end
            send_item(act, value, letters);
            if (act != ACT_UNUSED) begin
                done++;
            end
        end
    endtask

    initial begin
        tracker = new();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset codes: blank digits with the point on digit 2
        repeat (4) send_item(ACT_TICK, 16'hFFFF, '1);
        // Saturated leading digit, then a plain number
        send_item(ACT_NUMBER, 16'hFFFF, '0);
        repeat (4) send_item(ACT_TICK, 16'h0000, '0);
        send_item(ACT_NUMBER, 16'd9876, '1);
        repeat (4) send_item(ACT_TICK, 16'h5A5A, '0);
        // Letters below a, above z and at both ends
        send_item(ACT_MESSAGE, 16'h0000, {ASCII_Z, ASCII_A, 7'h7F, 7'h00});
        repeat (4) send_item(ACT_TICK, 16'hFFFF, '1);
        // Shapeless letters k, v, w, x and the unused action
        send_item(ACT_MESSAGE, 16'hFFFF, {7'h78, 7'h77, 7'h76, 7'h6B});
        send_item(ACT_UNUSED, 16'hFFFF, '1);
        repeat (3) send_item(ACT_TICK, 16'h0000, '0);

        // Random phases; the first lowers the duration below the live message age
        run_phase(130, 16'd1, 22, 59);
        run_phase(130, 16'hFFFF, 22, 59);
        run_phase(130, 16'd0, 59, 22);
        run_phase(130, 16'd4, 59, 22);
        run_phase(130, 16'd9, 0, 0);
        run_phase(130, 16'($urandom_range(12, 1)), 0, 0);

        s_axis_tvalid <= 1'b0;
        while (tracker.pending_readouts.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (END_SETTLE) @(posedge i_clk);

        $display("Sent %0d ticks, %0d number loads, %0d message loads, %0d ignored items",
                 n_ticks, n_numbers, n_messages, n_ignored);
        $display("Checked %0d readouts across seven durations and three idling mixes",
                 tracker.checked);
        if (tracker.mismatches == 0 && tracker.pending_readouts.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* files.f */
sv/ssd_pkg.sv
sv/ssd_in_stage.sv
sv/ssd_disp.sv
sv/seven_segment_scan_driver.sv
test/tb_top.sv
